FILE: design/usbhid_pkg.sv
// ----------------------------------------------------------------------------
// usbhid_pkg: shared types and constants for the interrupt endpoint finder
// Descriptor type codes, minimum lengths and endpoint field masks.
// ----------------------------------------------------------------------------
package usbhid_pkg;

    typedef logic [7:0] octet_t;

    // Descriptor type codes
    localparam octet_t TYPE_INTERFACE = 8'd4;
    localparam octet_t TYPE_ENDPOINT  = 8'd5;

    // Minimum lengths
    localparam octet_t MIN_DESC_LEN      = 8'd2;
    localparam octet_t MIN_INTERFACE_LEN = 8'd9;
    localparam octet_t MIN_ENDPOINT_LEN  = 8'd7;

    // Byte offsets inside a descriptor
    localparam octet_t OFS_LENGTH = 8'd0;
    localparam octet_t OFS_TYPE   = 8'd1;
    localparam octet_t OFS_ADDR   = 8'd2;
    localparam octet_t OFS_ATTR   = 8'd3;
    localparam octet_t OFS_CLASS  = 8'd5;

    // Endpoint fields
    localparam octet_t DIR_IN_BIT     = 8'h80;
    localparam octet_t XFER_TYPE_MASK = 8'h03;
    localparam octet_t XFER_INTERRUPT = 8'h03;

    // Class code after reset (HID)
    localparam octet_t CLASS_RESET = 8'd3;

endpackage

FILE: design/usb_hid_interrupt_endpoint_finder.sv
// ----------------------------------------------------------------------------
// usb_hid_interrupt_endpoint_finder
// Walks a configuration descriptor set byte by byte and reports the first
// interrupt IN endpoint under an interface whose class matches match_class.
// ----------------------------------------------------------------------------
//  channel  | direction | ports                                   | words
//  s_       | in        | s_descriptor_byte, s_last_byte          | one byte each
//  m_       | out       | m_endpoint_address, m_found             | one per last byte
//  cfg_     | in        | cfg_data (match_class)                  | one register
//
//  Each byte passes an input register and is parsed while held there; the
//  result register loads as the last byte leaves the input register, and
//  m_valid comes from the result register. Throughput is one byte per cycle,
//  set by the single parse stage, while no held result stalls a last byte.
//  A held result stalls only a last byte; other bytes keep flowing.
//  Reset clears the parser and sets match_class to 3.
// ----------------------------------------------------------------------------
module usb_hid_interrupt_endpoint_finder (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  usbhid_pkg::octet_t   s_descriptor_byte,
    input  logic                 s_last_byte,
    output logic                 m_valid,
    input  logic                 m_ready,
    output usbhid_pkg::octet_t   m_endpoint_address,
    output logic                 m_found,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  usbhid_pkg::octet_t   cfg_data
);
    import usbhid_pkg::*;

    // Input register
    logic   in_valid_reg, in_valid_next;
    octet_t in_byte_reg;
    logic   in_last_reg;

    // Configuration
    octet_t match_class_reg;

    // Parser state
    octet_t offset_reg, offset_next;
    octet_t length_reg, length_next;
    octet_t type_reg, type_next;
    logic   match_if_reg, match_if_next;
    octet_t addr_reg, addr_next;
    logic   pend_reg, pend_next;
    octet_t result_reg, result_next;
    logic   stopped_reg, stopped_next;

    // Result register
    logic   out_valid_reg, out_valid_next;
    octet_t out_addr_reg;
    logic   out_found_reg;

    logic   advance;
    logic   out_load;
    octet_t type_cur;
    octet_t addr_cur;
    logic   pend_cur;
    octet_t result_cur;
    logic   desc_end;

    assign advance   = in_valid_reg && (!in_last_reg || !out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign out_load  = advance && in_last_reg;
    assign cfg_ready = 1'b1;

    assign m_valid            = out_valid_reg;
    assign m_endpoint_address = out_addr_reg;
    assign m_found            = out_found_reg;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    // Parse one byte
    always_comb begin
        offset_next   = offset_reg;
        length_next   = length_reg;
        type_next     = type_reg;
        match_if_next = match_if_reg;
        addr_next     = addr_reg;
        pend_next     = pend_reg;
        stopped_next  = stopped_reg;
        type_cur      = (offset_reg == OFS_TYPE) ? in_byte_reg : type_reg;
        addr_cur      = (offset_reg == OFS_ADDR) ? in_byte_reg : addr_reg;
        pend_cur      = pend_reg;
        result_cur    = result_reg;
        desc_end      = (9'(offset_reg) + 9'd1) == 9'(length_reg);

        if (type_cur == TYPE_ENDPOINT && offset_reg == OFS_ATTR) begin
            pend_cur = (in_byte_reg & XFER_TYPE_MASK) == XFER_INTERRUPT;
        end
        if (type_cur == TYPE_INTERFACE && offset_reg == OFS_CLASS) begin
            pend_cur = in_byte_reg == match_class_reg;
        end

        if (advance && !stopped_reg) begin
            if (offset_reg == OFS_LENGTH) begin
                if (in_byte_reg < MIN_DESC_LEN) begin
                    stopped_next = 1'b1;
                end else begin
                    length_next = in_byte_reg;
                    pend_next   = 1'b0;
                    offset_next = 8'd1;
                end
            end else begin
                type_next = type_cur;
                addr_next = addr_cur;
                pend_next = pend_cur;
                if (desc_end) begin
                    offset_next = '0;
                    if (type_cur == TYPE_INTERFACE && length_reg >= MIN_INTERFACE_LEN) begin
                        match_if_next = pend_cur;
                    end else if (type_cur == TYPE_ENDPOINT
                                 && length_reg >= MIN_ENDPOINT_LEN
                                 && match_if_reg && result_reg == '0
                                 && (addr_cur & DIR_IN_BIT) != '0 && pend_cur) begin
                        result_cur = addr_cur;
                    end
                end else begin
                    offset_next = offset_reg + 8'd1;
                end
            end
        end
        result_next = result_cur;

        // End of set: drop all parse state
        if (out_load) begin
            offset_next   = '0;
            length_next   = '0;
            type_next     = '0;
            match_if_next = 1'b0;
            addr_next     = '0;
            pend_next     = 1'b0;
            result_next   = '0;
            stopped_next  = 1'b0;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg && !m_ready;
        if (out_load) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            match_class_reg <= CLASS_RESET;
            offset_reg      <= '0;
            length_reg      <= '0;
            type_reg        <= '0;
            match_if_reg    <= 1'b0;
            addr_reg        <= '0;
            pend_reg        <= 1'b0;
            result_reg      <= '0;
            stopped_reg     <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready) begin
                match_class_reg <= cfg_data;
            end
            offset_reg   <= offset_next;
            length_reg   <= length_next;
            type_reg     <= type_next;
            match_if_reg <= match_if_next;
            addr_reg     <= addr_next;
            pend_reg     <= pend_next;
            result_reg   <= result_next;
            stopped_reg  <= stopped_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_descriptor_byte;
            in_last_reg <= s_last_byte;
        end
        if (out_load) begin
            out_addr_reg  <= result_cur;
            out_found_reg <= result_cur != '0;
        end
    end

    // A found address is always an IN address
    a_found_is_in: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_found |-> m_endpoint_address[7])
        else $error("found endpoint without IN bit");

    a_none_is_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_found |-> m_endpoint_address == '0)
        else $error("nonzero address without found");

    // Latched address holds until the end of the set
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        result_reg != '0 && !out_load |=> result_reg == $past(result_reg))
        else $error("latched address changed");

    a_stopped_offset: assert property (@(posedge aclk) disable iff (!aresetn)
        stopped_reg |-> offset_reg == '0)
        else $error("parser stopped inside a descriptor");

    // A full input register takes a new word only while it drains
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && in_valid_reg |-> advance)
        else $error("input word overwritten");

endmodule
